>>> hw/rtl/mtqd_pkg.sv
`default_nettype none
package mtqd_pkg;

    // Ring geometry and port fan-out
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int MAX_PORTS   = 4;
    localparam int PORT_W      = 4;
    localparam int PCNT_W      = 3;

    // Item kinds
    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    // Status bytes that carry data (channel nibble cleared)
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_POLY_AT   = 8'hA0;
    localparam logic [7:0] ST_CTRL      = 8'hB0;
    localparam logic [7:0] ST_PROG      = 8'hC0;
    localparam logic [7:0] ST_CHAN_AT   = 8'hD0;
    localparam logic [7:0] ST_PITCH     = 8'hE0;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_MTC       = 8'hF1;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [3:0] SYS_NIBBLE   = 4'hF;

    typedef struct packed {
        logic       mode;
        logic [7:0] command;
        logic [3:0] channel;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic [3:0] exclude_mask;
        logic [3:0] port_ready;
    } in_item_t;

    typedef struct packed {
        logic [3:0] dest_mask;
        logic [7:0] out_command;
        logic [3:0] out_channel;
        logic [7:0] out_data_first;
        logic [7:0] out_data_second;
        logic [1:0] data_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0] command;
        logic [3:0] channel;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [3:0] excl;
    } entry_t;

    // Number of data bytes that follow a status byte
    function automatic logic [1:0] data_bytes_for(input logic [7:0] cmd);
        logic [7:0] c;
        logic [1:0] n;
        c = (cmd[7:4] == SYS_NIBBLE) ? cmd : {cmd[7:4], 4'h0};
        case (c)
            ST_PROG, ST_CHAN_AT, ST_SYSEX, ST_MTC, ST_SONG_SEL: n = 2'd1;
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCH, ST_SONG_POS: n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    // Mask of ports in use, port count saturated to MAX_PORTS
    function automatic logic [PORT_W-1:0] in_use_mask(input logic [PCNT_W-1:0] pc);
        logic [PCNT_W-1:0] ports;
        logic [PORT_W-1:0] m;
        ports = (pc > PCNT_W'(MAX_PORTS)) ? PCNT_W'(MAX_PORTS) : pc;
        for (int i = 0; i < PORT_W; i++) begin
            m[i] = (PCNT_W'(i) < ports);
        end
        return m;
    endfunction

    // Advance a ring index with wrap
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mtqd_in_reg.sv
`default_nettype none
module mtqd_in_reg
    import mtqd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     take,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    // Accept a new beat when empty or when the held one leaves this cycle
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/mtqd_ring.sv
`default_nettype none
module mtqd_ring
    import mtqd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire in_item_t          item,
    input  wire logic [PCNT_W-1:0] port_count,
    output logic                   hit,
    output out_item_t              result
);

    entry_t            entry_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  tail_next;
    logic [IDX_W-1:0]  head_eff;
    logic              send;
    logic [1:0]        n_in;
    entry_t            new_entry;
    entry_t            head_entry;
    logic              empty;
    logic [PORT_W-1:0] target;
    logic              ok;

    // Build the entry, zeroing bytes beyond the count
    assign send = (item.mode == MODE_SEND);
    assign n_in = data_bytes_for(item.command);
    always_comb begin
        new_entry.command = item.command;
        new_entry.channel = item.channel;
        new_entry.d0      = (n_in >= 2'd1) ? item.data_first  : 8'h00;
        new_entry.d1      = (n_in >= 2'd2) ? item.data_second : 8'h00;
        new_entry.excl    = item.exclude_mask;
    end

    // Advance tail on a send; drop the oldest entry when the ring wraps
    always_comb begin
        tail_next = send ? next_slot(tail_reg) : tail_reg;
        head_eff  = (send && (tail_next == head_reg)) ? next_slot(head_reg) : head_reg;
    end

    // Read head entry, forwarding the incoming one when it is the head
    assign head_entry = (send && (head_eff == tail_reg)) ? new_entry : entry_reg[head_eff];
    assign empty      = (head_eff == tail_next);
    assign target     = in_use_mask(port_count) & ~head_entry.excl;
    assign ok         = !empty && ((target & ~item.port_ready) == '0);
    assign hit        = fire && ok;
    assign head_next  = ok ? next_slot(head_eff) : head_eff;

    always_comb begin
        result.dest_mask       = target;
        result.out_command     = head_entry.command;
        result.out_channel     = head_entry.channel;
        result.out_data_first  = head_entry.d0;
        result.out_data_second = head_entry.d1;
        result.data_count      = data_bytes_for(head_entry.command);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else if (fire) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Write the entry store at the tail
    always_ff @(posedge aclk) begin
        if (fire && send) begin
            entry_reg[tail_reg] <= new_entry;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/midi_tx_queue_dispatch_unit.sv
`default_nettype none
// MIDI transmit queue with fan-out to up to four output ports.
// Input channel (s_valid/s_ready/s_data): a send beat enqueues one message
// into a 16-slot ring and then tries a dispatch; a poll beat only tries a
// dispatch. A full ring drops its oldest message, so at most 15 are held.
// A dispatch pops the head message only when every targeted port (in use
// and not excluded) shows its bit in port_ready, and then one result beat
// leaves on the result channel (m_valid/m_ready/m_data); otherwise the
// beat produces nothing.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes port_count and
// is always ready; the user must write it only while the block is idle.
// The block itself leaves that unenforced. A beat is held in the input
// register, and its result is loaded into the result register once the
// result slot is free or draining. One beat per cycle is taken while
// m_ready stays high; the pointer update and ready check are combinational.
// Reset (aresetn low, synchronous) empties the ring and clears port_count.
// When the receiver stalls, the held result waits and the input register
// fills; s_ready then drops until m_ready returns.
module midi_tx_queue_dispatch_unit
    import mtqd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [PCNT_W-1:0] cfg_data
);

    logic              item_valid;
    in_item_t          item;
    logic              take;
    logic              hit;
    out_item_t         result;
    logic [PCNT_W-1:0] port_count_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    out_item_t         m_data_reg;

    // Process the held beat when the result slot is free or draining
    assign take = item_valid && (!m_valid_reg || m_ready);

    mtqd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mtqd_ring u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (take),
        .item       (item),
        .port_count (port_count_reg),
        .hit        (hit),
        .result     (result)
    );

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_count_reg <= '0;
        end else if (cfg_valid) begin
            port_count_reg <= cfg_data;
        end
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = hit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
